FILE: src/temp_fixed_to_ascii_top_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
`ifndef TEMP_FIXED_TO_ASCII_TOP_MACROS_SVH
`define TEMP_FIXED_TO_ASCII_TOP_MACROS_SVH

// Checked only while out of reset.
`define TFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TFA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/tfa_pkg.sv
package tfa_pkg;

	localparam int TEMP_W = 16;
	localparam int CHAR_W = 8;
	localparam int WHOLE_W = 8;
	localparam int TXT_LEN = 7;
	localparam int IDX_W = 3;

	// Reading layout
	localparam logic [TEMP_W-1:0] NEG_MASK  = 16'hf800;
	localparam logic [TEMP_W-1:0] INT_MASK  = 16'h0ff0;
	localparam logic [TEMP_W-1:0] FRAC_MASK = 16'h000f;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

	// Fraction text for quarter steps: "00", "25", "50", "75"
	localparam logic [CHAR_W-1:0] FRAC_HI [4] = '{8'h30, 8'h32, 8'h35, 8'h37};
	localparam logic [CHAR_W-1:0] FRAC_LO [4] = '{8'h30, 8'h35, 8'h30, 8'h35};

	// Finished text of one reading, left aligned, with the index of its last character
	typedef struct packed {
		logic [TXT_LEN-1:0][CHAR_W-1:0] chars;
		logic [IDX_W-1:0]               last_idx;
	} tfa_txt_t;

endpackage

FILE: src/tfa_ifs.sv
// Reading channel
interface tfa_temp_if;
	logic                              valid;
	logic                              ready;
	logic signed [tfa_pkg::TEMP_W-1:0] temp_raw;

	modport source (output valid, output temp_raw, input ready);
	modport sink   (input valid, input temp_raw, output ready);
endinterface

// Character channel
interface tfa_char_if;
	logic                       valid;
	logic                       ready;
	logic [tfa_pkg::CHAR_W-1:0] char_code;
	logic                       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: src/temp_fixed_to_ascii_top.sv
// Temperature reading to ASCII text.
// temp_in carries one signed reading in 1/16 degree units per transaction.
// char_out carries the text one character per transaction: sign, one to
// three integer digits, '.', two fraction digits; last_char marks the final
// character of each reading, so a reading gives 5 to 7 transactions.
// A reading is registered in digit stages 1, 2 and 3 and then loaded into the
// serialiser's text buffer, from which its first character is output.
// Throughput: one character per cycle at the output while the receiver holds
// ready high, set by the character serialiser; the three-stage digit pipeline
// in front accepts a new reading every cycle while it has room, and the next
// text is loaded in the cycle its predecessor's last character is taken.
// Reset clears all valid bits: nothing is output until a reading arrives.
// When the receiver holds ready low the current character holds, the
// pipeline fills up behind it and temp_in.ready drops; nothing is lost or
// repeated.
module temp_fixed_to_ascii_top (
	input  logic       clk,
	input  logic       arst_n,
	tfa_temp_if.sink   temp_in,
	tfa_char_if.source char_out
);
	import tfa_pkg::*;

	tfa_txt_t txt;
	logic     txt_valid;
	logic     txt_ready;

	tfa_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.temp_in   (temp_in),
		.txt       (txt),
		.txt_valid (txt_valid),
		.txt_ready (txt_ready)
	);

	tfa_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.txt       (txt),
		.txt_valid (txt_valid),
		.txt_ready (txt_ready),
		.char_out  (char_out)
	);
endmodule

FILE: src/tfa_digits.sv
`include "temp_fixed_to_ascii_top_macros.svh"

module tfa_digits (
	input  logic              clk,
	input  logic              arst_n,
	tfa_temp_if.sink          temp_in,
	output tfa_pkg::tfa_txt_t txt,
	output logic              txt_valid,
	input  logic              txt_ready
);
	import tfa_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic               neg_s1;
	logic [WHOLE_W-1:0] whole_s1;
	logic [1:0]         fsel_s1;

	logic       neg_s2;
	logic [1:0] hund_s2;
	logic [6:0] rem_s2;
	logic [1:0] fsel_s2;

	tfa_txt_t txt_s3;

	// Stall chain: a stage takes new data when empty or when it drains
	assign rdy_s3 = !v_s3 || txt_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign temp_in.ready = rdy_s1;

	// Stage 1: sign test, negation, field split
	logic [TEMP_W-1:0] raw_u, mag;
	logic              neg_c;
	always_comb begin
		raw_u = TEMP_W'(temp_in.temp_raw);
		neg_c = (raw_u & NEG_MASK) != '0;
		mag   = neg_c ? (~raw_u + TEMP_W'(1)) : raw_u;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= temp_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && temp_in.valid) begin
			neg_s1   <= neg_c;
			whole_s1 <= WHOLE_W'((mag & INT_MASK) >> 4);
			fsel_s1  <= 2'(((mag & FRAC_MASK) >> 2));
		end
	end

	// Stage 2: hundreds digit by two compares, remainder below 100
	logic [1:0] hund_c;
	logic [6:0] rem_c;
	always_comb begin
		if (whole_s1 >= WHOLE_W'(200)) begin
			hund_c = 2'd2;
			rem_c  = 7'(whole_s1 - WHOLE_W'(200));
		end else if (whole_s1 >= WHOLE_W'(100)) begin
			hund_c = 2'd1;
			rem_c  = 7'(whole_s1 - WHOLE_W'(100));
		end else begin
			hund_c = 2'd0;
			rem_c  = 7'(whole_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			neg_s2  <= neg_s1;
			hund_s2 <= hund_c;
			rem_s2  <= rem_c;
			fsel_s2 <= fsel_s1;
		end
	end

	// Stage 3: tens by reciprocal multiply (x205 >> 11 is exact below 180), then text
	logic [14:0]       prod;
	logic [3:0]        tens_c, units_c;
	logic [6:0]        units_w;
	logic              show_h, show_t;
	tfa_txt_t          txt_c;
	logic [CHAR_W-1:0] h_ch, t_ch, u_ch, fh_ch, fl_ch;
	always_comb begin
		prod    = 15'(rem_s2) * 15'd205;
		tens_c  = prod[14:11];
		units_w = rem_s2 - 7'(7'(tens_c) * 7'd10);
		units_c = units_w[3:0];
		show_h  = hund_s2 != 2'd0;
		show_t  = show_h || (tens_c != 4'd0);
		h_ch    = CH_ZERO + CHAR_W'(hund_s2);
		t_ch    = CH_ZERO + CHAR_W'(tens_c);
		u_ch    = CH_ZERO + CHAR_W'(units_c);
		fh_ch   = FRAC_HI[fsel_s2];
		fl_ch   = FRAC_LO[fsel_s2];
		txt_c   = '0;
		txt_c.chars[0] = neg_s2 ? CH_MINUS : CH_PLUS;
		if (show_h) begin
			txt_c.chars[1] = h_ch;
			txt_c.chars[2] = t_ch;
			txt_c.chars[3] = u_ch;
			txt_c.chars[4] = CH_DOT;
			txt_c.chars[5] = fh_ch;
			txt_c.chars[6] = fl_ch;
			txt_c.last_idx = IDX_W'(6);
		end else if (show_t) begin
			txt_c.chars[1] = t_ch;
			txt_c.chars[2] = u_ch;
			txt_c.chars[3] = CH_DOT;
			txt_c.chars[4] = fh_ch;
			txt_c.chars[5] = fl_ch;
			txt_c.last_idx = IDX_W'(5);
		end else begin
			txt_c.chars[1] = u_ch;
			txt_c.chars[2] = CH_DOT;
			txt_c.chars[3] = fh_ch;
			txt_c.chars[4] = fl_ch;
			txt_c.last_idx = IDX_W'(4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			txt_s3 <= txt_c;
		end
	end

	assign txt       = txt_s3;
	assign txt_valid = v_s3;

	// Checks
	`TFA_ASSERT(a_s3_hold, v_s3 && !txt_ready |=> v_s3 && $stable(txt_s3), "stage 3 lost data on stall")
	`TFA_ASSERT(a_hund_range, v_s2 |-> hund_s2 != 2'd3, "hundreds digit out of range")
	`TFA_ASSERT(a_len_range, v_s3 |-> (txt_s3.last_idx == IDX_W'(4) || txt_s3.last_idx == IDX_W'(5) || txt_s3.last_idx == IDX_W'(6)), "bad text length")
endmodule

FILE: src/tfa_serial.sv
`include "temp_fixed_to_ascii_top_macros.svh"

module tfa_serial (
	input  logic              clk,
	input  logic              arst_n,
	input  tfa_pkg::tfa_txt_t txt,
	input  logic              txt_valid,
	output logic              txt_ready,
	tfa_char_if.source        char_out
);
	import tfa_pkg::*;

	logic                           busy_q;
	logic [IDX_W-1:0]               idx_q;
	logic [IDX_W-1:0]               last_q;
	logic [TXT_LEN-1:0][CHAR_W-1:0] buf_q;

	logic at_last, out_acc, load;

	assign at_last   = idx_q == last_q;
	assign out_acc   = busy_q && char_out.ready;
	// Next text loads as soon as the final character of the current one goes out
	assign txt_ready = !busy_q || (out_acc && at_last);
	assign load      = txt_valid && txt_ready;

	// Character pointer and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (out_acc) begin
			if (at_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Text buffer
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= txt.chars;
			last_q <= txt.last_idx;
		end
	end

	assign char_out.valid     = busy_q;
	assign char_out.char_code = buf_q[idx_q];
	assign char_out.last_char = at_last;

	// Checks
	`TFA_ASSERT(a_idx_bound, busy_q |-> idx_q <= last_q, "character pointer past end of text")
	`TFA_ASSERT(a_stall_hold, busy_q && !char_out.ready |=> busy_q && $stable(idx_q), "pointer moved on stall")
	`TFA_ASSERT(a_drain, out_acc && at_last && !txt_valid |=> !busy_q, "serialiser stayed busy after last character")
	`TFA_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !busy_q, "serialiser busy in reset")
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import tfa_pkg::*;

	// One character of expected text
	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} text_char_t;

	localparam int RANDOM_READINGS = 237;
	localparam int PHASE_LEN = 94;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 120;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [TEMP_W-1:0] DIRECTED [23] = '{
		16'h0000, 16'h0004, 16'h0008, 16'h000c, 16'h0003, 16'h0090, 16'h00a0,
		16'h0630, 16'h0640, 16'h0690, 16'h06e0, 16'h07ff, 16'h0800, 16'hf010,
		16'hfff0, 16'hffff, 16'h8000, 16'h7fff, 16'h9000, 16'hf9c0, 16'hff60,
		16'h5555, 16'haaaa
	};

	logic clk;
	logic arst_n;

	tfa_temp_if temp_ch ();
	tfa_char_if char_ch ();

	temp_fixed_to_ascii_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.temp_in (temp_ch),
		.char_out(char_ch)
	);

	logic [TEMP_W-1:0] readings_q [$];
	text_char_t        pending_chars [$];
	int                readings_taken;
	int                err_cnt;
	int                tx_idle_pct;
	int                rx_idle_pct;
	int                hold_left;
	logic              hold_done;
	int                stall_cnt;

	// Expected text of one reading, appended to pending_chars
	function automatic void predict_text(logic [TEMP_W-1:0] raw);
		logic              neg;
		logic [TEMP_W-1:0] mag;
		logic [7:0]        whole;
		logic [1:0]        qtr;
		int                hund;
		int                tens;
		int                units;
		int                frac;
		neg = (raw & NEG_MASK) != '0;
		mag = neg ? TEMP_W'(-raw) : raw;
		whole = mag[11:4];
		qtr = mag[3:2];
		hund = whole / 100;
		tens = (whole / 10) % 10;
		units = whole % 10;
		frac = qtr * 25;
		pending_chars.push_back('{neg ? CH_MINUS : CH_PLUS, 1'b0});
		if (hund != 0)
			pending_chars.push_back('{CH_ZERO + CHAR_W'(hund), 1'b0});
		if (hund != 0 || tens != 0)
			pending_chars.push_back('{CH_ZERO + CHAR_W'(tens), 1'b0});
		pending_chars.push_back('{CH_ZERO + CHAR_W'(units), 1'b0});
		pending_chars.push_back('{CH_DOT, 1'b0});
		pending_chars.push_back('{CH_ZERO + CHAR_W'(frac / 10), 1'b0});
		pending_chars.push_back('{CH_ZERO + CHAR_W'(frac % 10), 1'b1});
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle rates: sender busy-ish first, then receiver, then neither idles
	always_comb begin
		if (readings_taken < PHASE_LEN) begin
			tx_idle_pct = 38;
			rx_idle_pct = 55;
		end else if (readings_taken < 2 * PHASE_LEN) begin
			tx_idle_pct = 55;
			rx_idle_pct = 38;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	end

	// Reading driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_ch.valid <= 1'b0;
			temp_ch.temp_raw <= '0;
		end else if (!temp_ch.valid || temp_ch.ready) begin
			if (readings_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				temp_ch.valid <= 1'b1;
				temp_ch.temp_raw <= readings_q.pop_front();
			end else begin
				temp_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each reading taken, checks each character taken,
	// and drives ready including one long hold-off
	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			char_ch.ready <= 1'b0;
			readings_taken <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (temp_ch.valid && temp_ch.ready) begin
				predict_text(temp_ch.temp_raw);
				readings_taken <= readings_taken + 1;
			end
			if (char_ch.valid && char_ch.ready) begin
				if (pending_chars.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("%0t: unexpected character %h last=%b", $realtime,
							char_ch.char_code, char_ch.last_char);
				end else begin
					want = pending_chars.pop_front();
					if (char_ch.char_code !== want.code || char_ch.last_char !== want.last) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("%0t: mismatch: expected %h '%c' last=%b, got %h '%c' last=%b",
								$realtime, want.code, want.code, want.last,
								char_ch.char_code, char_ch.char_code, char_ch.last_char);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				char_ch.ready <= 1'b0;
			end else if (!hold_done && readings_taken >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				char_ch.ready <= 1'b0;
			end else begin
				char_ch.ready <= $urandom_range(99) >= rx_idle_pct;
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (temp_ch.valid && temp_ch.ready) || (char_ch.valid && char_ch.ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		logic [TEMP_W-1:0] mag;
		logic [7:0]        whole;
		// clean falling edge so every asynchronous reset fires
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			readings_q.push_back(DIRECTED[i]);
		for (int i = 0; i < RANDOM_READINGS; i++) begin
			case ($urandom_range(3))
				0: readings_q.push_back(TEMP_W'($urandom));
				1: readings_q.push_back(TEMP_W'($urandom_range(16'h07ff)));
				2: begin
					mag = TEMP_W'($urandom_range(16'h0fff, 1));
					readings_q.push_back(TEMP_W'(-mag));
				end
				default: begin
					// integer parts on digit boundaries, random fraction
					case ($urandom_range(9))
						0: whole = 8'd0;
						1: whole = 8'd9;
						2: whole = 8'd10;
						3: whole = 8'd99;
						4: whole = 8'd100;
						5: whole = 8'd109;
						6: whole = 8'd110;
						7: whole = 8'd127;
						8: whole = 8'd200;
						default: whole = 8'd255;
					endcase
					mag = {4'h0, whole, 4'($urandom)};
					if (whole > 8'd127 || $urandom_range(1))
						readings_q.push_back(TEMP_W'(-mag));
					else
						readings_q.push_back(mag);
				end
			endcase
		end

		#1 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (readings_q.size() != 0 || temp_ch.valid)
			@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0 && pending_chars.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
